[rtl/tlgc_pkg.sv]
// Package for the torus lattice greedy coloring block.
// Holds sizes, mode codes, register indexes and the request, result and divider types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlgc_pkg;
  localparam int NodeBits    = 16;
  localparam int Nodes       = 1 << NodeBits;
  localparam int SlotBits    = 10;
  localparam int StencilDepth = 1 << SlotBits;
  localparam int ColorBits   = 10;
  localparam int MaxColors   = 1023;
  localparam int DimBits     = 9;
  localparam int CntBits     = 11;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [2:0] REG_DIM_X = 3'd0;
  localparam logic [2:0] REG_DIM_Y = 3'd1;
  localparam logic [2:0] REG_DIM_Z = 3'd2;
  localparam logic [2:0] REG_DIM_T = 3'd3;
  localparam logic [2:0] REG_COUNT = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] node_index;
    logic [9:0]  stencil_slot;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [7:0]  offset_z;
    logic [7:0]  offset_t;
  } req_t;

  typedef struct packed {
    logic [9:0] assigned_color;
    logic [9:0] highest_color;
    logic       out_of_colors;
  } rsp_t;

  typedef struct packed {
    logic          start;
    logic [8:0]    dim;
    logic [16:0]   num;
  } div_cmd_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
    logic [8:0]  rem;
  } div_rsp_t;
endpackage
`default_nettype wire

[rtl/tlgc_if.sv]
// Valid/ready channel interface carrying one request or result.
// Depends on tlgc_pkg for the request and result types.
`timescale 1ns / 1ps
`default_nettype none
interface tlgc_req_if;
  import tlgc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlgc_rsp_if;
  import tlgc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/torus_lattice_greedy_coloring.sv]
// Top level of the torus lattice greedy coloring block: sequencer, stores.
// Depends on tlgc_pkg, tlgc_if and tlgc_divider.
//
//  channel | dir | handshake      | payload
//  in      | in  | valid/ready    | mode, node_index, stencil_slot, offsets
//  out     | out | valid/ready    | assigned_color, highest_color, out_of_colors
//  cfg     | in  | write enable   | cfg_index, cfg_data (11 bits)
//
// A color request is accepted, then split into coordinates (four divides on the
// shared divider); each stencil entry takes four modulo reductions on the
// divider, 4 multiply-adds, a color read and a mark; then come the free-color
// scan over colors 1 to 1023, the clear of all 1024 marks and the finish. Clear
// sweeps 65536 entries, one a cycle, as does the pass after reset; no request is
// taken meanwhile. A waiting result holds off the next request until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module torus_lattice_greedy_coloring
  import tlgc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  tlgc_req_if.sink                in_ch,
  tlgc_rsp_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CntBits-1:0] cfg_data
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_DIVW, S_ENT, S_SUM, S_NDIV, S_NDIVW, S_MUL, S_RD,
    S_MARK, S_SCAN, S_WIPE, S_DONE
  } state_t;

  state_t state_r;
  logic [DimBits-1:0] dim_r [4];
  logic [CntBits-1:0] count_r;

  logic [ColorBits-1:0] colors_mem [Nodes];
  logic [31:0]          sten_mem [StencilDepth];
  logic                 marks_mem [MaxColors+1];

  req_t        req_r;
  logic [1:0]  k_r;
  logic [16:0] num_r;
  logic [7:0]  c_r [4];
  logic [10:0] j_r;
  logic [31:0] ent_r;
  logic [7:0]  n_r [4];
  logic [NodeBits:0] clr_r;
  logic [ColorBits-1:0] col_r, rd_r, max_r;
  logic [ColorBits:0] scan_r;
  logic        mark_rd_r;
  logic [15:0] idx_r;
  logic [2:0]  mstep_r;
  rsp_t        rsp_r;
  logic        ovalid_r;
  div_cmd_t    dcmd;
  div_rsp_t    drsp;
  logic [8:0]  ext [4];
  logic [10:0] cnt_sat;
  logic [8:0]  sum9;
  logic [25:0] prod;

  tlgc_divider u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .rsp(drsp));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ext[i] = (dim_r[i] == 9'd0) ? 9'd1 : dim_r[i];
      if (dim_r[i] > 9'd256) ext[i] = 9'd256;
    end
    cnt_sat = (count_r > 11'(StencilDepth)) ? 11'(StencilDepth) : count_r;
    sum9  = {1'b0, c_r[k_r]} + {1'b0, ent_r[8*k_r +: 8]};
    prod  = 26'({8'd0, idx_r} * {17'd0, ext[k_r]}) + 26'(n_r[k_r]);
    dcmd.start = (state_r == S_DIV) || (state_r == S_NDIV);
    dcmd.dim   = ext[k_r];
    dcmd.num   = num_r;
  end

  assign in_ch.ready   = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid  = ovalid_r;
  assign out_ch.data   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) dim_r[i] <= 9'd16;
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_X: dim_r[0] <= cfg_data[8:0];
        REG_DIM_Y: dim_r[1] <= cfg_data[8:0];
        REG_DIM_Z: dim_r[2] <= cfg_data[8:0];
        REG_DIM_T: dim_r[3] <= cfg_data[8:0];
        REG_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) colors_mem[clr_r[NodeBits-1:0]] <= '0;
    else if (state_r == S_DONE && mstep_r == 3'd0)
      colors_mem[req_r.node_index] <= col_r;
    rd_r <= colors_mem[idx_r];
    if (in_ch.valid && in_ch.ready && mode_t'(in_ch.data.mode) == MODE_LOAD)
      sten_mem[in_ch.data.stencil_slot] <= {in_ch.data.offset_t, in_ch.data.offset_z,
                                          in_ch.data.offset_y, in_ch.data.offset_x};
    ent_r <= sten_mem[j_r[SlotBits-1:0]];
    if (state_r == S_MARK) marks_mem[rd_r] <= 1'b1;
    else if (state_r == S_WIPE || state_r == S_CLEAR)
      marks_mem[scan_r[ColorBits-1:0]] <= 1'b0;
    mark_rd_r <= marks_mem[scan_r[ColorBits-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      scan_r   <= '0;
      ovalid_r <= 1'b0;
      max_r    <= '0;
      mstep_r  <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r  <= clr_r + 1'b1;
          if (clr_r == (NodeBits+1)'(Nodes - 1)) begin
            state_r <= S_IDLE;
            scan_r  <= '0;
          end else if (scan_r != 11'(MaxColors)) scan_r <= scan_r + 11'd1;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          req_r <= in_ch.data;
          rsp_r <= '{assigned_color: '0,
                     highest_color: (mode_t'(in_ch.data.mode) == MODE_CLEAR) ? '0 : max_r,
                     out_of_colors: 1'b0};
          case (mode_t'(in_ch.data.mode))
            MODE_COLOR: begin
              num_r   <= {1'b0, in_ch.data.node_index};
              k_r     <= '0;
              state_r <= S_DIV;
            end
            MODE_CLEAR: begin
              max_r   <= '0;
              clr_r   <= '0;
              ovalid_r <= 1'b1;
              state_r <= S_CLEAR;
            end
            default: ovalid_r <= 1'b1;
          endcase
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: if (drsp.done) begin
          c_r[k_r] <= drsp.rem[7:0];
          num_r    <= drsp.quot;
          k_r      <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            j_r <= '0;
            state_r <= (cnt_sat == 11'd0) ? S_SCAN : S_ENT;
            scan_r <= 11'd1;
          end else state_r <= S_DIV;
        end
        S_ENT: begin
          k_r <= '0;
          state_r <= S_SUM;
        end
        // neighbor coordinate reduced modulo the extent on the shared divider
        S_SUM: begin
          num_r   <= {8'd0, sum9};
          state_r <= S_NDIV;
        end
        S_NDIV: state_r <= S_NDIVW;
        S_NDIVW: if (drsp.done) begin
          n_r[k_r] <= drsp.rem[7:0];
          if (k_r == 2'd3) begin
            idx_r <= '0;
            state_r <= S_MUL;
          end else begin
            k_r <= k_r + 2'd1;
            state_r <= S_SUM;
          end
        end
        // linear index, last axis first
        S_MUL: begin
          idx_r <= prod[15:0];
          k_r   <= k_r - 2'd1;
          if (k_r == 2'd0) state_r <= S_RD;
        end
        S_RD: begin
          if (mstep_r == 3'd1) begin
            mstep_r <= '0;
            state_r <= S_MARK;
          end else mstep_r <= mstep_r + 3'd1;
        end
        S_MARK: begin
          j_r <= j_r + 11'd1;
          if (j_r + 11'd1 == cnt_sat) state_r <= S_SCAN;
          else state_r <= S_ENT;
          mstep_r <= 3'd0;
        end
        S_SCAN: begin
          // each color's mark is read through the registered mark_rd_r before it is tested
          if (mstep_r == 3'd1) begin
            mstep_r <= '0;
            if (!mark_rd_r) begin
              col_r <= scan_r[ColorBits-1:0];
              scan_r <= '0;
              state_r <= S_WIPE;
            end else if (scan_r == 11'(MaxColors)) begin
              col_r <= '0;
              scan_r <= '0;
              state_r <= S_WIPE;
            end else scan_r <= scan_r + 11'd1;
          end else mstep_r <= mstep_r + 3'd1;
        end
        S_WIPE: begin
          if (scan_r == 11'(MaxColors)) begin
            scan_r <= '0;
            state_r <= S_DONE;
          end else scan_r <= scan_r + 11'd1;
        end
        S_DONE: begin
          rsp_r.assigned_color <= col_r;
          rsp_r.out_of_colors  <= (col_r == '0);
          if (col_r > max_r) begin
            max_r <= col_r;
            rsp_r.highest_color <= col_r;
          end else rsp_r.highest_color <= max_r;
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (max_r >= $past(max_r))) else $error("max fell");
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && rsp_r.out_of_colors) |-> (rsp_r.assigned_color == '0))
    else $error("flag with color");
endmodule
`default_nettype wire

[rtl/tlgc_divider.sv]
// Shared restoring divider: 17-bit numerator by 9-bit divisor, one bit a cycle.
// Depends on tlgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlgc_divider
  import tlgc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire div_cmd_t cmd,
  output div_rsp_t  rsp
);
  logic [16:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [8:0]  d_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [9:0]  trial;

  always_comb begin
    trial   = {rem_r[8:0], q_r[16]};
    rem_nxt = trial;
    q_nxt   = {q_r[15:0], 1'b0};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt  = trial - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'd17;
      q_r    <= cmd.num;
      rem_r  <= '0;
      d_r    <= cmd.dim;
    end else if (busy_r) begin
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - 5'd1;
      busy_r <= (cnt_r != 5'd1);
      done_r <= (cnt_r == 5'd1);
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[8:0];
endmodule
`default_nettype wire

[sim/torus_lattice_greedy_coloring_tb.sv]
// Testbench for torus_lattice_greedy_coloring: directed table, register runs, random phases, full stencil.
// Every result is checked field by field against the table's result or a behavioral coloring predictor.
// Depends on tlgc_pkg, tlgc_if and the block's RTL.
`timescale 1ns / 1ps
module torus_lattice_greedy_coloring_tb;
  import tlgc_pkg::*;

  localparam int IdleLimit = 1000000;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } step_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;

  tlgc_req_if in_ch ();
  tlgc_rsp_if out_ch ();

  torus_lattice_greedy_coloring u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [9:0]  color_mem [Nodes];
  logic [31:0] offset_mem [StencilDepth];
  bit          slot_loaded [StencilDepth];
  logic [8:0]  ext_reg [4];
  logic [10:0] count_reg;
  logic [9:0]  top_color;

  rsp_t expected_q [$];
  int   error_count;
  int   idle_cycles;
  int   burst_left;
  int   clears_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned extent_of(logic [8:0] d);
    if (d == 0) return 1;
    if (d > 256) return 256;
    return d;
  endfunction

  function automatic int loaded_prefix();
    int p;
    p = 0;
    while (p < StencilDepth && slot_loaded[p]) p++;
    return p;
  endfunction

  function automatic rsp_t color_request(req_t r);
    rsp_t            o;
    int unsigned     d [4];
    int unsigned     c [4];
    int unsigned     nb [4];
    int unsigned     rest, cnt, col;
    longint unsigned lin;
    bit [1023:0]     used;
    o = '0;
    case (mode_t'(r.mode))
      MODE_LOAD: begin
        offset_mem[r.stencil_slot] = {r.offset_t, r.offset_z, r.offset_y, r.offset_x};
        slot_loaded[r.stencil_slot] = 1'b1;
      end
      MODE_CLEAR: begin
        foreach (color_mem[i]) color_mem[i] = '0;
        top_color = '0;
      end
      MODE_COLOR: begin
        rest = r.node_index;
        for (int k = 0; k < 4; k++) begin
          d[k] = extent_of(ext_reg[k]);
          c[k] = rest % d[k];
          rest = rest / d[k];
        end
        cnt = (count_reg > StencilDepth) ? StencilDepth : count_reg;
        used = '0;
        for (int j = 0; j < cnt; j++) begin
          for (int k = 0; k < 4; k++)
            nb[k] = (c[k] + offset_mem[j][8*k +: 8]) % d[k];
          lin = nb[0] + longint'(d[0]) * (nb[1] + longint'(d[1]) *
                (nb[2] + longint'(d[2]) * nb[3]));
          used[color_mem[lin[15:0]]] = 1'b1;
        end
        col = 1;
        while (col <= MaxColors && used[col]) col++;
        if (col > MaxColors) begin
          o.out_of_colors = 1'b1;
          color_mem[r.node_index] = '0;
        end else begin
          o.assigned_color = 10'(col);
          color_mem[r.node_index] = 10'(col);
          if (col > top_color) top_color = 10'(col);
        end
      end
      default: ;
    endcase
    o.highest_color = top_color;
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // one request, with bursty sender gaps
  task automatic send_request(req_t r, bit typed = 1'b0, rsp_t typed_rsp = '0);
    rsp_t pred;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    pred = color_request(r);
    expected_q.push_back(typed ? typed_rsp : pred);
    burst_left--;
  endtask

  // waits for every result and for the block to be idle again
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_q.size() != 0 || !in_ch.ready);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(logic [10:0] dx, logic [10:0] dy, logic [10:0] dz,
                            logic [10:0] dt, logic [10:0] cnt);
    logic [10:0] vals [5];
    vals = '{dx, dy, dz, dt, cnt};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      if (i < 4) ext_reg[i] = vals[i][8:0];
      else count_reg = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic req_t make_req(mode_t m, logic [15:0] node, logic [9:0] slot,
                                    logic [31:0] offs);
    req_t r;
    r = '0;
    r.mode = m;
    r.node_index = node;
    r.stencil_slot = slot;
    {r.offset_t, r.offset_z, r.offset_y, r.offset_x} = offs;
    return r;
  endfunction

  function automatic req_t random_req(int prefix);
    req_t r;
    int   pick;
    r = '0;
    {r.node_index, r.stencil_slot} = 26'($urandom);
    {r.offset_t, r.offset_z, r.offset_y, r.offset_x} = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 78) r.mode = MODE_COLOR;
    else if (pick < 93) begin
      r.mode = MODE_LOAD;
      if ($urandom_range(0, 1) && prefix < StencilDepth) r.stencil_slot = 10'(prefix);
    end else if (pick < 95 && clears_left > 0) begin
      r.mode = MODE_CLEAR;
      clears_left--;
    end else r.mode = MODE_NOP;
    return r;
  endfunction

  function automatic logic [10:0] random_dim();
    case ($urandom_range(0, 7))
      0: return 11'd1;
      1: return 11'd256;
      2: return 11'd0;
      3: return 11'($urandom_range(257, 511));
      default: return 11'($urandom_range(1, 20));
    endcase
  endfunction

  // receiver: stall density changes after each random ready_span
  int unsigned ready_pct;
  int          ready_span;
  always @(posedge clk) begin
    if (!rst_n) begin
      ready_span <= 0;
      ready_pct  <= 100;
      out_ch.ready <= 1'b0;
    end else begin
      if (ready_span == 0) begin
        ready_span <= $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 70;
          2: ready_pct <= 30;
          default: ready_pct <= 5;
        endcase
      end else ready_span <= ready_span - 1;
      out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("[%0t] result with no request outstanding", $realtime);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.data.assigned_color != want.assigned_color)
          report("assigned_color", out_ch.data.assigned_color, want.assigned_color);
        if (out_ch.data.highest_color != want.highest_color)
          report("highest_color", out_ch.data.highest_color, want.highest_color);
        if (out_ch.data.out_of_colors != want.out_of_colors)
          report("out_of_colors", out_ch.data.out_of_colors, want.out_of_colors);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  step_t directed [] = '{
    '{make_req(MODE_COLOR, 16'h0000, 10'd0, 32'h0), 1'b1, '{10'd1, 10'd1, 1'b0}},
    '{make_req(MODE_COLOR, 16'hFFFF, 10'd0, 32'h0), 1'b1, '{10'd1, 10'd1, 1'b0}},
    '{make_req(MODE_NOP, 16'hFFFF, 10'h3FF, 32'hFFFFFFFF), 1'b1, '{10'd0, 10'd1, 1'b0}},
    '{make_req(MODE_CLEAR, 16'h0, 10'd0, 32'h0), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_LOAD, 16'h0, 10'd0, 32'h00000001), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_LOAD, 16'h0, 10'd1, 32'h00000100), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_LOAD, 16'h0, 10'd2, 32'h00FF0000), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_LOAD, 16'h0, 10'd3, 32'hFF000000), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_LOAD, 16'h0, 10'd4, 32'h00000000), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_LOAD, 16'hFFFF, 10'h3FF, 32'hFFFFFFFF), 1'b1, '{10'd0, 10'd0, 1'b0}},
    '{make_req(MODE_COLOR, 16'h0000, 10'd0, 32'h0), 1'b1, '{10'd1, 10'd1, 1'b0}},
    '{make_req(MODE_COLOR, 16'h0001, 10'd0, 32'h0), 1'b1, '{10'd1, 10'd1, 1'b0}}
  };

  step_t after_count [] = '{
    '{make_req(MODE_COLOR, 16'h0000, 10'd0, 32'h0), 1'b0, '0},
    '{make_req(MODE_COLOR, 16'h0001, 10'd0, 32'h0), 1'b0, '0},
    '{make_req(MODE_COLOR, 16'h000F, 10'd0, 32'h0), 1'b0, '0},
    '{make_req(MODE_COLOR, 16'hFFFF, 10'd0, 32'h0), 1'b0, '0},
    '{make_req(MODE_COLOR, 16'h8000, 10'd0, 32'h0), 1'b0, '0},
    '{make_req(MODE_COLOR, 16'h1234, 10'd0, 32'h0), 1'b0, '0}
  };

  initial begin
    int prefix;
    int cnt_hi;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    clears_left = 3;
    foreach (color_mem[i]) color_mem[i] = '0;
    foreach (offset_mem[i]) offset_mem[i] = '0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    ext_reg = '{9'd16, 9'd16, 9'd16, 9'd16};
    count_reg = '0;
    top_color = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].rsp);
    wait_drained();
    write_regs(11'd16, 11'd16, 11'd16, 11'd16, 11'd5);
    foreach (after_count[i]) send_request(after_count[i].req);
    wait_drained();
    write_regs(11'd1, 11'd256, 11'd0, 11'd511, 11'd5);
    foreach (after_count[i]) send_request(after_count[i].req);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      prefix = loaded_prefix();
      cnt_hi = (prefix < 12) ? prefix : 12;
      write_regs(random_dim(), random_dim(), random_dim(), random_dim(),
                 11'($urandom_range(0, cnt_hi)));
      repeat ($urandom_range(50, 70)) send_request(random_req(loaded_prefix()));
      wait_drained();
    end

    // fill the whole stencil table, then saturate the count
    for (int s = 0; s < StencilDepth; s++)
      send_request(make_req(MODE_LOAD, 16'($urandom), s[9:0], $urandom));
    wait_drained();
    write_regs(11'd4, 11'd4, 11'd8, 11'd8, 11'd2047);
    repeat (3) send_request(make_req(MODE_COLOR, 16'($urandom), 10'd0, 32'h0));
    wait_drained();
    write_regs(random_dim(), random_dim(), random_dim(), random_dim(), 11'd1024);
    repeat (3) send_request(make_req(MODE_COLOR, 16'($urandom), 10'd0, 32'h0));
    wait_drained();
    write_regs(11'd16, 11'd16, 11'd16, 11'd16, 11'd0);
    repeat (4) send_request(random_req(StencilDepth));
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
